// File: sv/psf_pkg.sv
// Package for the pendulum state feedback unit: widths, fixed-point constants,
// operation and register codes, and the gain bundle type.
// No dependencies; used by psf_drive_calc and pendulum_state_feedback_unit.
package psf_pkg;

    // Field widths
    localparam int COUNT_BITS  = 16;
    localparam int SAMPLE_BITS = 10;
    localparam int POS_W       = 32;
    localparam int ANGLE_W     = 24;
    localparam int GAIN_W      = 24;
    localparam int DRIVE_W     = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;

    // Position step: (left - right) * meters-per-pulse, Q32 -> Q19
    localparam int DIFF_W      = COUNT_BITS + 1;
    localparam int MPP_W       = 23;
    localparam logic signed [MPP_W-1:0] MPP_Q32 = 23'sd2177548;
    localparam int STEP_SHIFT  = 13;
    localparam int STEP_PROD_W = DIFF_W + MPP_W;
    localparam int STEP_W      = STEP_PROD_W - STEP_SHIFT;
    localparam logic signed [STEP_PROD_W-1:0] STEP_HALF =
        STEP_PROD_W'(1) << (STEP_SHIFT - 1);

    // Sample to angle: sample * radians-per-step, Q32 -> Q20
    localparam int RPA_W       = 25;
    localparam logic [RPA_W-1:0] RPA_Q32 = 25'd26379350;
    localparam int SA_SHIFT    = 12;
    localparam int SA_PROD_W   = SAMPLE_BITS + RPA_W + 1;
    localparam int SA_W        = SA_PROD_W - SA_SHIFT;
    localparam int SA_CMP_W    = (SA_W > ANGLE_W) ? SA_W : ANGLE_W;
    localparam logic [SA_PROD_W-1:0] SA_HALF = SA_PROD_W'(1) << (SA_SHIFT - 1);

    // Position accumulate and saturate
    localparam int PSUM_W  = ((STEP_W > POS_W) ? STEP_W : POS_W) + 1;
    localparam int POS_MAX = 2147483647;
    localparam int POS_MIN = -POS_MAX - 1;

    // Angle arithmetic
    localparam int ADIFF_W   = ANGLE_W + 1;
    localparam int ANGLE_MAX = 2 ** (ANGLE_W - 1) - 1;
    localparam int ANGLE_MIN = -ANGLE_MAX - 1;

    // Feedback operands
    localparam int VEL_W  = POS_W + 1;
    localparam int RATE_W = ANGLE_W + 1;

    // Reference trim, Q20 factors
    localparam int TRIM_W      = 22;
    localparam logic signed [TRIM_W-1:0] TRIM_UP_Q20 = 22'sd1050673;
    localparam logic signed [TRIM_W-1:0] TRIM_DN_Q20 = 22'sd1046479;
    localparam int TRIM_SHIFT  = 20;
    localparam int TRIM_PROD_W = ANGLE_W + TRIM_W;
    localparam int TRIM_RES_W  = TRIM_PROD_W - TRIM_SHIFT;
    localparam logic signed [TRIM_PROD_W-1:0] TRIM_HALF =
        TRIM_PROD_W'(1) << (TRIM_SHIFT - 1);

    // Drive sum: Q.36 -> Q2.14
    localparam int DSUM_W      = GAIN_W + VEL_W + 3;
    localparam int DRIVE_SHIFT = 22;
    localparam int DFULL_W     = DSUM_W - DRIVE_SHIFT;
    localparam int DRIVE_ONE   = 16384;
    localparam logic signed [DSUM_W-1:0] DRIVE_HALF =
        DSUM_W'(1) << (DRIVE_SHIFT - 1);

    // Register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_POS_RST  = GAIN_W'(-414489);
    localparam logic signed [GAIN_W-1:0] GAIN_VEL_RST  = GAIN_W'(-967842);
    localparam logic signed [GAIN_W-1:0] GAIN_ANG_RST  = GAIN_W'(-2407740);
    localparam logic signed [GAIN_W-1:0] GAIN_RATE_RST = GAIN_W'(-473937);
    localparam logic signed [POS_W-1:0]  POS_UPPER_RST = POS_W'(524288000);
    localparam logic signed [POS_W-1:0]  POS_LOWER_RST = POS_W'(-524288000);

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_CAPTURE   = 2'd1,
        OP_TRIM_UP   = 2'd2,
        OP_TRIM_DOWN = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_POS   = 3'd0,
        REG_GAIN_VEL   = 3'd1,
        REG_GAIN_ANG   = 3'd2,
        REG_GAIN_RATE  = 3'd3,
        REG_POS_UPPER  = 3'd4,
        REG_POS_LOWER  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] position;
        logic [GAIN_W-1:0] velocity;
        logic [GAIN_W-1:0] angle;
        logic [GAIN_W-1:0] angle_rate;
    } t_gains;

endpackage

// File: sv/psf_drive_calc.sv
// Drive computation back end: four gain products, then sum, negate, round
// and saturate into the output word register. Uses psf_pkg.
module psf_drive_calc (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  psf_pkg::t_gains                      i_gains,
    input  logic signed [psf_pkg::POS_W-1:0]     i_pos_raw,
    input  logic signed [psf_pkg::VEL_W-1:0]     i_vel,
    input  logic signed [psf_pkg::ANGLE_W-1:0]   i_angle,
    input  logic signed [psf_pkg::RATE_W-1:0]    i_rate,
    input  logic signed [psf_pkg::POS_W-1:0]     i_pos_now,
    output logic                                 o_valid,
    output logic signed [psf_pkg::DRIVE_W-1:0]   o_drive,
    output logic signed [psf_pkg::POS_W-1:0]     o_position_now,
    output logic signed [psf_pkg::ANGLE_W-1:0]   o_angle_now,
    output logic                                 o_drive_saturated
);

    localparam int PPOS_W  = psf_pkg::GAIN_W + psf_pkg::POS_W;
    localparam int PVEL_W  = psf_pkg::GAIN_W + psf_pkg::VEL_W;
    localparam int PANG_W  = psf_pkg::GAIN_W + psf_pkg::ANGLE_W;
    localparam int PRATE_W = psf_pkg::GAIN_W + psf_pkg::RATE_W;
    localparam logic signed [psf_pkg::DFULL_W-1:0] DRV_MAX =
        psf_pkg::DFULL_W'(psf_pkg::DRIVE_ONE);
    localparam logic signed [psf_pkg::DFULL_W-1:0] DRV_MIN =
        psf_pkg::DFULL_W'(-psf_pkg::DRIVE_ONE);

    logic signed [psf_pkg::GAIN_W-1:0] w_g_pos, w_g_vel, w_g_ang, w_g_rate;
    logic signed [PPOS_W-1:0]  n_p_pos,  r_p_pos;
    logic signed [PVEL_W-1:0]  n_p_vel,  r_p_vel;
    logic signed [PANG_W-1:0]  n_p_ang,  r_p_ang;
    logic signed [PRATE_W-1:0] n_p_rate, r_p_rate;
    logic                               r_p_valid;
    logic signed [psf_pkg::POS_W-1:0]   r_p_pos_now;
    logic signed [psf_pkg::ANGLE_W-1:0] r_p_angle;

    logic signed [psf_pkg::DSUM_W-1:0]  w_sum, w_neg, w_rnd;
    logic signed [psf_pkg::DFULL_W-1:0] w_full;
    logic signed [psf_pkg::DRIVE_W-1:0] n_drive;
    logic                               n_sat;

    logic                               r_valid;
    logic signed [psf_pkg::DRIVE_W-1:0] r_drive;
    logic signed [psf_pkg::POS_W-1:0]   r_pos_now;
    logic signed [psf_pkg::ANGLE_W-1:0] r_angle;
    logic                               r_sat;

    assign w_g_pos  = i_gains.position;
    assign w_g_vel  = i_gains.velocity;
    assign w_g_ang  = i_gains.angle;
    assign w_g_rate = i_gains.angle_rate;

    assign n_p_pos  = w_g_pos  * i_pos_raw;
    assign n_p_vel  = w_g_vel  * i_vel;
    assign n_p_ang  = w_g_ang  * i_angle;
    assign n_p_rate = w_g_rate * i_rate;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_pos     <= n_p_pos;
            r_p_vel     <= n_p_vel;
            r_p_ang     <= n_p_ang;
            r_p_rate    <= n_p_rate;
            r_p_pos_now <= i_pos_now;
            r_p_angle   <= i_angle;
        end
    end

    // Sum, negate, round half up, saturate to +-1.0
    assign w_sum  = r_p_pos + r_p_vel + r_p_ang + r_p_rate;
    assign w_neg  = -w_sum;
    assign w_rnd  = w_neg + psf_pkg::DRIVE_HALF;
    assign w_full = w_rnd[psf_pkg::DSUM_W-1:psf_pkg::DRIVE_SHIFT];

    always_comb begin
        n_sat   = 1'b0;
        n_drive = w_full[psf_pkg::DRIVE_W-1:0];
        if (w_full > DRV_MAX) begin
            n_drive = psf_pkg::DRIVE_W'(psf_pkg::DRIVE_ONE);
            n_sat   = 1'b1;
        end else if (w_full < DRV_MIN) begin
            n_drive = psf_pkg::DRIVE_W'(-psf_pkg::DRIVE_ONE);
            n_sat   = 1'b1;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drive   <= n_drive;
            r_pos_now <= r_p_pos_now;
            r_angle   <= r_p_angle;
            r_sat     <= n_sat;
        end
    end

    assign o_valid           = r_valid;
    assign o_drive           = r_drive;
    assign o_position_now    = r_pos_now;
    assign o_angle_now       = r_angle;
    assign o_drive_saturated = r_sat;

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sat) |->
        (r_drive == psf_pkg::DRIVE_W'(psf_pkg::DRIVE_ONE) ||
         r_drive == psf_pkg::DRIVE_W'(-psf_pkg::DRIVE_ONE)))
        else $error("saturated drive not at full scale");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_drive <= psf_pkg::DRIVE_W'(psf_pkg::DRIVE_ONE) &&
                     r_drive >= psf_pkg::DRIVE_W'(-psf_pkg::DRIVE_ONE)))
        else $error("drive outside +-1.0");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_p_valid) |=> r_valid)
        else $error("product stage word lost");

endmodule

// File: sv/pendulum_state_feedback_unit.sv
// Top level of the pendulum state feedback unit: input and state stages,
// configuration registers, and the drive back end (psf_drive_calc, psf_pkg).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per operation:
//   a control tick with encoder counts and angle sample, a reference capture,
//   or a reference trim up or down. Only control ticks yield a result word on
//   the output channel (o_out_valid / i_out_ready); other operations only
//   update the angle reference.
//   Ticks pass the input, state, operand and product stages to the output
//   word register. Throughput: one word per cycle when not stalled. Position,
//   angle reference and previous values live in the state stage (second
//   pipeline stage), so a following word sees them updated with no bubble.
//   Stall: the pipeline is a single enable chain; while the output word sits
//   unaccepted, every stage holds and o_in_ready is low.
//   Reset (synchronous, active low): pipeline empty, state zero, gains and
//   position limits back to their default values.
//   Configuration: write i_cfg_data to register i_cfg_index with i_cfg_we,
//   only while no word is in flight.
module pendulum_state_feedback_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [psf_pkg::CFG_W-1:0]                i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [1:0]                               i_operation,
    input  logic signed [psf_pkg::COUNT_BITS-1:0]    i_left_count,
    input  logic signed [psf_pkg::COUNT_BITS-1:0]    i_right_count,
    input  logic [psf_pkg::SAMPLE_BITS-1:0]          i_angle_sample,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [psf_pkg::DRIVE_W-1:0]       o_drive,
    output logic signed [psf_pkg::POS_W-1:0]         o_position_now,
    output logic signed [psf_pkg::ANGLE_W-1:0]       o_angle_now,
    output logic                                     o_drive_saturated
);

    localparam logic signed [psf_pkg::PSUM_W-1:0] PSUM_MAX =
        psf_pkg::PSUM_W'(psf_pkg::POS_MAX);
    localparam logic signed [psf_pkg::PSUM_W-1:0] PSUM_MIN =
        psf_pkg::PSUM_W'(psf_pkg::POS_MIN);
    localparam logic signed [psf_pkg::ADIFF_W-1:0] ADIFF_MAX =
        psf_pkg::ADIFF_W'(psf_pkg::ANGLE_MAX);
    localparam logic signed [psf_pkg::ADIFF_W-1:0] ADIFF_MIN =
        psf_pkg::ADIFF_W'(psf_pkg::ANGLE_MIN);
    localparam logic signed [psf_pkg::TRIM_RES_W-1:0] TRES_MAX =
        psf_pkg::TRIM_RES_W'(psf_pkg::ANGLE_MAX);
    localparam logic signed [psf_pkg::TRIM_RES_W-1:0] TRES_MIN =
        psf_pkg::TRIM_RES_W'(psf_pkg::ANGLE_MIN);
    localparam logic [psf_pkg::SA_CMP_W-1:0] SA_MAX =
        psf_pkg::SA_CMP_W'(psf_pkg::ANGLE_MAX);

    logic w_en;

    // Configuration registers
    psf_pkg::t_gains                   r_gains;
    logic signed [psf_pkg::POS_W-1:0]  r_pos_upper, r_pos_lower;

    // Input stage
    logic                                   r_s1_valid;
    psf_pkg::t_op                           r_s1_op;
    logic signed [psf_pkg::COUNT_BITS-1:0]  r_s1_left, r_s1_right;
    logic [psf_pkg::SAMPLE_BITS-1:0]        r_s1_sample;

    logic signed [psf_pkg::DIFF_W-1:0]      w_diff;
    logic signed [psf_pkg::STEP_PROD_W-1:0] w_step_prod, w_step_rnd;
    logic signed [psf_pkg::STEP_W-1:0]      n_s2_step;
    logic [psf_pkg::SA_PROD_W-1:0]          w_sa_prod, w_sa_rnd;
    logic [psf_pkg::SA_W-1:0]               w_sa_full;
    logic signed [psf_pkg::ANGLE_W-1:0]     n_s2_sa;

    // State stage
    logic                                   r_s2_valid;
    psf_pkg::t_op                           r_s2_op;
    logic signed [psf_pkg::STEP_W-1:0]      r_s2_step;
    logic signed [psf_pkg::ANGLE_W-1:0]     r_s2_sa;

    logic signed [psf_pkg::POS_W-1:0]       r_position, r_prev_position;
    logic signed [psf_pkg::ANGLE_W-1:0]     r_prev_angle, r_angle_ref;

    logic signed [psf_pkg::PSUM_W-1:0]      w_pos_sum;
    logic signed [psf_pkg::POS_W-1:0]       w_pos_raw, w_pos_hi, w_pos_clamp;
    logic signed [psf_pkg::ADIFF_W-1:0]     w_ang_diff;
    logic signed [psf_pkg::ANGLE_W-1:0]     w_angle;
    logic signed [psf_pkg::TRIM_W-1:0]      w_trim_f;
    logic signed [psf_pkg::TRIM_PROD_W-1:0] w_trim_prod, w_trim_rnd;
    logic signed [psf_pkg::TRIM_RES_W-1:0]  w_trim_res;
    logic signed [psf_pkg::ANGLE_W-1:0]     w_trim_sat;

    // Operand stage, feeding the drive back end
    logic                                   r_s3_valid;
    logic signed [psf_pkg::POS_W-1:0]       r_s3_pos_raw, r_s3_pos_now;
    logic signed [psf_pkg::VEL_W-1:0]       r_s3_vel;
    logic signed [psf_pkg::ANGLE_W-1:0]     r_s3_angle;
    logic signed [psf_pkg::RATE_W-1:0]      r_s3_rate;

    // Whole pipeline advances unless the output word is held
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.position   <= psf_pkg::GAIN_POS_RST;
            r_gains.velocity   <= psf_pkg::GAIN_VEL_RST;
            r_gains.angle      <= psf_pkg::GAIN_ANG_RST;
            r_gains.angle_rate <= psf_pkg::GAIN_RATE_RST;
            r_pos_upper        <= psf_pkg::POS_UPPER_RST;
            r_pos_lower        <= psf_pkg::POS_LOWER_RST;
        end else if (i_cfg_we) begin
            case (psf_pkg::t_reg_idx'(i_cfg_index))
                psf_pkg::REG_GAIN_POS:  r_gains.position   <= i_cfg_data[psf_pkg::GAIN_W-1:0];
                psf_pkg::REG_GAIN_VEL:  r_gains.velocity   <= i_cfg_data[psf_pkg::GAIN_W-1:0];
                psf_pkg::REG_GAIN_ANG:  r_gains.angle      <= i_cfg_data[psf_pkg::GAIN_W-1:0];
                psf_pkg::REG_GAIN_RATE: r_gains.angle_rate <= i_cfg_data[psf_pkg::GAIN_W-1:0];
                psf_pkg::REG_POS_UPPER: r_pos_upper        <= i_cfg_data[psf_pkg::POS_W-1:0];
                psf_pkg::REG_POS_LOWER: r_pos_lower        <= i_cfg_data[psf_pkg::POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- Input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op     <= psf_pkg::t_op'(i_operation);
            r_s1_left   <= i_left_count;
            r_s1_right  <= i_right_count;
            r_s1_sample <= i_angle_sample;
        end
    end

    // Position step, round half up into Q8.19
    assign w_diff      = r_s1_left - r_s1_right;
    assign w_step_prod = w_diff * psf_pkg::MPP_Q32;
    assign w_step_rnd  = w_step_prod + psf_pkg::STEP_HALF;
    assign n_s2_step   = w_step_rnd[psf_pkg::STEP_PROD_W-1:psf_pkg::STEP_SHIFT];

    // Sample angle, round half up into Q4.20, saturate (never negative)
    assign w_sa_prod = psf_pkg::SA_PROD_W'(r_s1_sample) * psf_pkg::SA_PROD_W'(psf_pkg::RPA_Q32);
    assign w_sa_rnd  = w_sa_prod + psf_pkg::SA_HALF;
    assign w_sa_full = w_sa_rnd[psf_pkg::SA_PROD_W-1:psf_pkg::SA_SHIFT];
    assign n_s2_sa   = (psf_pkg::SA_CMP_W'(w_sa_full) > SA_MAX) ?
                       psf_pkg::ANGLE_W'(psf_pkg::ANGLE_MAX) :
                       psf_pkg::ANGLE_W'(psf_pkg::SA_CMP_W'(w_sa_full));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op   <= r_s1_op;
            r_s2_step <= n_s2_step;
            r_s2_sa   <= n_s2_sa;
        end
    end

    // ---------------- State stage ----------------
    assign w_pos_sum = r_position + r_s2_step;
    assign w_pos_raw = (w_pos_sum > PSUM_MAX) ? psf_pkg::POS_W'(psf_pkg::POS_MAX) :
                       (w_pos_sum < PSUM_MIN) ? psf_pkg::POS_W'(psf_pkg::POS_MIN) :
                       w_pos_sum[psf_pkg::POS_W-1:0];

    // Upper limit first, then lower: lower wins if the limits cross
    assign w_pos_hi    = (w_pos_raw >= r_pos_upper) ? r_pos_upper : w_pos_raw;
    assign w_pos_clamp = (w_pos_hi <= r_pos_lower) ? r_pos_lower : w_pos_hi;

    assign w_ang_diff = r_angle_ref - r_s2_sa;
    assign w_angle    = (w_ang_diff > ADIFF_MAX) ? psf_pkg::ANGLE_W'(psf_pkg::ANGLE_MAX) :
                        (w_ang_diff < ADIFF_MIN) ? psf_pkg::ANGLE_W'(psf_pkg::ANGLE_MIN) :
                        w_ang_diff[psf_pkg::ANGLE_W-1:0];

    assign w_trim_f    = (r_s2_op == psf_pkg::OP_TRIM_UP) ? psf_pkg::TRIM_UP_Q20 :
                                                            psf_pkg::TRIM_DN_Q20;
    assign w_trim_prod = r_angle_ref * w_trim_f;
    assign w_trim_rnd  = w_trim_prod + psf_pkg::TRIM_HALF;
    assign w_trim_res  = w_trim_rnd[psf_pkg::TRIM_PROD_W-1:psf_pkg::TRIM_SHIFT];
    assign w_trim_sat  = (w_trim_res > TRES_MAX) ? psf_pkg::ANGLE_W'(psf_pkg::ANGLE_MAX) :
                         (w_trim_res < TRES_MIN) ? psf_pkg::ANGLE_W'(psf_pkg::ANGLE_MIN) :
                         w_trim_res[psf_pkg::ANGLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position      <= '0;
            r_prev_position <= '0;
            r_prev_angle    <= '0;
            r_angle_ref     <= '0;
        end else if (w_en && r_s2_valid) begin
            case (r_s2_op)
                psf_pkg::OP_TICK: begin
                    r_position      <= w_pos_clamp;
                    r_prev_position <= w_pos_raw;
                    r_prev_angle    <= w_angle;
                end
                psf_pkg::OP_CAPTURE: begin
                    r_angle_ref <= r_s2_sa;
                end
                psf_pkg::OP_TRIM_UP,
                psf_pkg::OP_TRIM_DOWN: begin
                    r_angle_ref <= w_trim_sat;
                end
                default: begin
                end
            endcase
        end
    end

    // Only ticks travel on to the drive back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid && (r_s2_op == psf_pkg::OP_TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_pos_raw <= w_pos_raw;
            r_s3_pos_now <= w_pos_clamp;
            r_s3_vel     <= w_pos_raw - r_prev_position;
            r_s3_angle   <= w_angle;
            r_s3_rate    <= r_prev_angle - w_angle;
        end
    end

    psf_drive_calc u_drive (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (r_s3_valid),
        .i_gains           (r_gains),
        .i_pos_raw         (r_s3_pos_raw),
        .i_vel             (r_s3_vel),
        .i_angle           (r_s3_angle),
        .i_rate            (r_s3_rate),
        .i_pos_now         (r_s3_pos_now),
        .o_valid           (o_out_valid),
        .o_drive           (o_drive),
        .o_position_now    (o_position_now),
        .o_angle_now       (o_angle_now),
        .o_drive_saturated (o_drive_saturated)
    );

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_position) && $stable(r_angle_ref)))
        else $error("state changed while output word held");

    a_non_tick_keeps_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_s2_valid && r_s2_op != psf_pkg::OP_TICK) |=>
        ($stable(r_position) && $stable(r_prev_position) && $stable(r_prev_angle)))
        else $error("non-tick operation moved position state");

    a_clamp_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_pos_lower <= r_pos_upper) |->
        (w_pos_clamp <= r_pos_upper && w_pos_clamp >= r_pos_lower))
        else $error("clamped position outside limits");

endmodule
